[sv/tarl_pkg.sv]
// Shared types and codes for the tile adjacency rule learner.
package tarl_pkg;

	// Bits of a tile state on the ports
	localparam int ST_W = 6;

	// Request codes on req_type
	localparam logic [1:0] REQ_TILE  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	// Operations handed from the front to the back
	typedef enum logic [1:0] {
		OP_TILE  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	// Neighbor directions, also the row group of the rule store
	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	// One classified command
	typedef struct packed {
		op_t             op;
		logic [ST_W-1:0] st;
		logic [ST_W-1:0] up;
		logic            has_up;
		logic [ST_W-1:0] left;
		logic            has_left;
		logic [ST_W-1:0] qstate;
		dir_t            qdir;
	} cmd_t;

endpackage

[sv/tile_adjacency_rule_learner_top.sv]
// Top level of the tile adjacency rule learner.
//
// Input side looks like a queue: a beat is taken when push is high and full
// is low. req_type selects a tile sample, a rule row read or a clear.
// Tiles arrive in raster order; start_of_image restarts the position.
// Results look like a queue too: while empty is low the oldest read result
// sits on rule_row, state_count and total_tiles and is taken with pop.
// image_width is written through cfg_valid/cfg_ready/cfg_data (ready is
// always high); write it only while the block is idle, as the block itself
// does not enforce this. The front takes one beat per cycle while full is
// low. In the back a tile makes one read-modify-write of a rule row for
// each direction (up, down, left, right) that has a neighbor, on the single
// write port of the rule RAM. A read result goes through the front stage
// register, the command queue, the back stage register and the result queue
// before it can be popped. Reset clears the rule store and counts at once
// through valid bits; there is no sweep. When the result queue (four beats)
// fills, the back holds read commands, the command queue fills and full rises.
module tile_adjacency_rule_learner_top #(
	parameter int NUM_STATES = 64,
	parameter int MAX_WIDTH  = 1024,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  req_type,
	input  logic [5:0]  tile_state,
	input  logic        start_of_image,
	input  logic [5:0]  query_state,
	input  logic [1:0]  query_direction,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        empty,
	input  logic        pop,
	output logic [63:0] rule_row,
	output logic [31:0] state_count,
	output logic [31:0] total_tiles
);

	localparam int CMD_DEPTH = 4;
	localparam int OUT_DEPTH = 4;
	localparam int OLW       = $clog2(OUT_DEPTH + 1);
	localparam int CMD_W     = $bits(tarl_pkg::cmd_t);

	logic [10:0]      image_width_q;
	logic             cmd_push;
	tarl_pkg::cmd_t   cmd_in;
	logic             cmd_full;
	logic             cmd_empty;
	logic             cmd_pop;
	logic [CMD_W-1:0] cmd_head_bits;
	tarl_pkg::cmd_t   cmd_head;
	logic [OLW-1:0]   out_level;
	logic             out_push;
	logic [127:0]     out_data;
	logic             out_full;
	logic [127:0]     out_head;

	// Width register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= 11'd1;
		end else if (cfg_valid && cfg_ready) begin
			image_width_q <= cfg_data;
		end
	end

	tarl_front #(
		.NUM_STATES(NUM_STATES),
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req_type       (req_type),
		.tile_state     (tile_state),
		.start_of_image (start_of_image),
		.query_state    (query_state),
		.query_direction(query_direction),
		.image_width    (image_width_q),
		.cmd_push       (cmd_push),
		.cmd_data       (cmd_in),
		.cmd_full       (cmd_full)
	);

	// Command queue between front and back
	tarl_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(CMD_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_head_bits),
		.empty (cmd_empty),
		.level ()
	);

	assign cmd_head = tarl_pkg::cmd_t'(cmd_head_bits);

	tarl_back #(
		.NUM_STATES(NUM_STATES),
		.COUNT_BITS(COUNT_BITS),
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_v   (!cmd_empty),
		.head     (cmd_head),
		.head_pop (cmd_pop),
		.out_level(out_level),
		.out_push (out_push),
		.out_data (out_data)
	);

	// Result queue
	tarl_fifo #(
		.WIDTH(128),
		.DEPTH(OUT_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (out_push),
		.wdata (out_data),
		.full  (out_full),
		.pop   (pop),
		.rdata (out_head),
		.empty (empty),
		.level (out_level)
	);

	assign rule_row    = out_head[127:64];
	assign state_count = out_head[63:32];
	assign total_tiles = out_head[31:0];

	a_no_result_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue overflow");

endmodule

[sv/tarl_ram.sv]
// Generic simple dual-port RAM with registered, read-first output.
module tarl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read; a same-address read sees the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[sv/tarl_fifo.sv]
// Small flip-flop queue with level output.
module tarl_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] level
);

	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [LW-1:0]    level_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (level_q == LW'(DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];
	assign level   = level_q;

	// Store the beat at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LW'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LW'(1);
			end
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LW'(DEPTH))
		else $error("queue level above depth");

endmodule

[sv/tarl_front.sv]
// Front end: raster tracking, line buffer lookup and command classification.
module tarl_front #(
	parameter int NUM_STATES = 64,
	parameter int MAX_WIDTH  = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                req_type,
	input  logic [tarl_pkg::ST_W-1:0] tile_state,
	input  logic                      start_of_image,
	input  logic [tarl_pkg::ST_W-1:0] query_state,
	input  logic [1:0]                query_direction,
	input  logic [10:0]               image_width,
	output logic                      cmd_push,
	output tarl_pkg::cmd_t            cmd_data,
	input  logic                      cmd_full
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int PW = (CW + 1 > 11) ? CW + 1 : 11;
	localparam int SW = tarl_pkg::ST_W;

	logic [CW-1:0]  col_q;
	logic           first_row_q;
	logic [SW-1:0]  left_q;

	logic           s1_v_q;
	tarl_pkg::cmd_t cmd_s1;
	logic           has_up_s1;

	logic           advance;
	logic           accept;
	logic           tile_ok;
	logic           keep;
	logic [CW-1:0]  col_now;
	logic           first_now;
	logic [PW-1:0]  w_nz;
	logic [PW-1:0]  w_eff;
	logic [PW-1:0]  col_inc;
	logic [SW-1:0]  up_rd;
	tarl_pkg::cmd_t cmd_new;

	assign advance = !s1_v_q || !cmd_full;
	assign full    = !advance;
	assign accept  = push && advance;

	// Classify the incoming beat
	assign tile_ok = accept && (req_type == tarl_pkg::REQ_TILE)
		&& ({1'b0, tile_state} < (SW + 1)'(NUM_STATES));
	assign keep = tile_ok
		|| (accept && (req_type == tarl_pkg::REQ_READ || req_type == tarl_pkg::REQ_CLEAR));

	// Position of this tile and the effective row width
	assign col_now   = start_of_image ? '0 : col_q;
	assign first_now = start_of_image || first_row_q;
	assign w_nz      = (image_width == '0) ? PW'(1) : PW'(image_width);
	assign w_eff     = (w_nz > PW'(MAX_WIDTH)) ? PW'(MAX_WIDTH) : w_nz;
	assign col_inc   = PW'(col_now) + PW'(1);

	// Line buffer: read the tile above and overwrite it in the same beat
	tarl_ram #(
		.WIDTH(SW),
		.DEPTH(MAX_WIDTH)
	) u_line_buf (
		.clk  (clk),
		.we   (tile_ok),
		.waddr(col_now),
		.wdata(tile_state),
		.re   (tile_ok),
		.raddr(col_now),
		.rdata(up_rd)
	);

	// Build the command for the first stage
	always_comb begin
		cmd_new          = '0;
		cmd_new.st       = tile_state;
		cmd_new.left     = left_q;
		cmd_new.has_left = (col_now != '0);
		cmd_new.qstate   = query_state;
		cmd_new.qdir     = tarl_pkg::dir_t'(query_direction);
		case (req_type)
			tarl_pkg::REQ_READ:  cmd_new.op = tarl_pkg::OP_READ;
			tarl_pkg::REQ_CLEAR: cmd_new.op = tarl_pkg::OP_CLEAR;
			default:             cmd_new.op = tarl_pkg::OP_TILE;
		endcase
	end

	// Track raster position and left neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			first_row_q <= 1'b1;
			left_q      <= '0;
		end else if (tile_ok) begin
			left_q <= tile_state;
			if (col_inc >= w_eff) begin
				col_q       <= '0;
				first_row_q <= 1'b0;
			end else begin
				col_q       <= col_inc[CW-1:0];
				first_row_q <= first_now;
			end
		end
	end

	// Stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (advance) begin
			s1_v_q <= keep;
		end
	end

	// Stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= cmd_new;
			has_up_s1 <= !first_now;
		end
	end

	// Merge the line buffer word and hand off
	always_comb begin
		cmd_data        = cmd_s1;
		cmd_data.up     = up_rd;
		cmd_data.has_up = has_up_s1 && ({1'b0, up_rd} < (SW + 1)'(NUM_STATES));
	end

	assign cmd_push = s1_v_q && !cmd_full;

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		PW'(col_q) < PW'(MAX_WIDTH))
		else $error("column position out of range");

endmodule

[sv/tarl_back.sv]
// Back end: rule store and count read-modify-write, reads and clears.
module tarl_back #(
	parameter int NUM_STATES = 64,
	parameter int COUNT_BITS = 32,
	parameter int OUT_DEPTH  = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           head_v,
	input  tarl_pkg::cmd_t                 head,
	output logic                           head_pop,
	input  logic [$clog2(OUT_DEPTH+1)-1:0] out_level,
	output logic                           out_push,
	output logic [127:0]                   out_data
);

	localparam int RAW = $clog2(4 * NUM_STATES);
	localparam int SAW = $clog2(NUM_STATES);
	localparam int SW  = tarl_pkg::ST_W;
	localparam int LW  = $clog2(OUT_DEPTH + 1);
	localparam int EXT = (COUNT_BITS > 32) ? COUNT_BITS : 33;

	logic [1:0]              step_q;
	logic [4*NUM_STATES-1:0] row_ok_q;
	logic [NUM_STATES-1:0]   cnt_ok_q;
	logic [COUNT_BITS-1:0]   total_q;

	logic                  b1_v_q;
	tarl_pkg::op_t         b1_op_q;
	logic [RAW-1:0]        b1_addr_q;
	logic [NUM_STATES-1:0] b1_mask_q;
	logic                  b1_en_q;
	logic                  b1_cnt_q;
	logic [SAW-1:0]        b1_caddr_q;
	logic                  b1_qok_q;
	logic                  b1_fwd_q;
	logic [NUM_STATES-1:0] b1_fwd_data_q;

	logic                  go;
	logic                  last;
	tarl_pkg::dir_t        i_dir;
	logic [SW-1:0]         i_st;
	logic [SW-1:0]         i_nb;
	logic                  i_en;
	logic [RAW-1:0]        i_addr;
	logic [SAW-1:0]        i_caddr;
	logic                  i_cnt;
	logic                  i_cre;
	logic                  i_qok;
	logic                  rd_in_b1;

	logic [NUM_STATES-1:0] rule_rd;
	logic [NUM_STATES-1:0] old_rule;
	logic [NUM_STATES-1:0] new_rule;
	logic                  rule_we;
	logic [COUNT_BITS-1:0] cnt_rd;
	logic [COUNT_BITS-1:0] old_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  cnt_we;
	logic [EXT-1:0]        cnt_ext;
	logic [EXT-1:0]        tot_ext;
	logic [31:0]           cnt_out;
	logic [31:0]           tot_out;

	assign rd_in_b1 = b1_v_q && (b1_op_q == tarl_pkg::OP_READ);
	assign i_qok    = ({1'b0, head.qstate} < (SW + 1)'(NUM_STATES));

	// Select this step's rule row and neighbor
	always_comb begin
		i_dir   = tarl_pkg::DIR_UP;
		i_st    = head.st;
		i_nb    = head.up;
		i_en    = 1'b0;
		i_cnt   = 1'b0;
		i_cre   = 1'b0;
		i_caddr = head.st[SAW-1:0];
		go      = 1'b1;
		last    = 1'b1;
		case (head.op)
			tarl_pkg::OP_TILE: begin
				last = (step_q == 2'd3);
				case (step_q)
					2'd0: begin
						i_dir = tarl_pkg::DIR_UP;
						i_st  = head.st;
						i_nb  = head.up;
						i_en  = head.has_up;
						i_cnt = 1'b1;
						i_cre = 1'b1;
					end
					2'd1: begin
						i_dir = tarl_pkg::DIR_DOWN;
						i_st  = head.up;
						i_nb  = head.st;
						i_en  = head.has_up;
					end
					2'd2: begin
						i_dir = tarl_pkg::DIR_LEFT;
						i_st  = head.st;
						i_nb  = head.left;
						i_en  = head.has_left;
					end
					default: begin
						i_dir = tarl_pkg::DIR_RIGHT;
						i_st  = head.left;
						i_nb  = head.st;
						i_en  = head.has_left;
					end
				endcase
			end
			tarl_pkg::OP_READ: begin
				i_dir   = head.qdir;
				i_st    = head.qstate;
				i_caddr = head.qstate[SAW-1:0];
				i_cre   = 1'b1;
				go      = ((LW + 1)'(out_level) + (LW + 1)'(rd_in_b1)) < (LW + 1)'(OUT_DEPTH);
			end
			default: begin
				go = 1'b1;
			end
		endcase
	end

	assign i_addr   = RAW'(i_dir) * RAW'(NUM_STATES) + RAW'(i_st);
	assign head_pop = head_v && go && last;

	// Rule rows and per-state counts
	tarl_ram #(
		.WIDTH(NUM_STATES),
		.DEPTH(4 * NUM_STATES)
	) u_rule_ram (
		.clk  (clk),
		.we   (rule_we),
		.waddr(b1_addr_q),
		.wdata(new_rule),
		.re   (head_v && go),
		.raddr(i_addr),
		.rdata(rule_rd)
	);

	tarl_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(NUM_STATES)
	) u_count_ram (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(b1_caddr_q),
		.wdata(new_cnt),
		.re   (head_v && go && i_cre),
		.raddr(i_caddr),
		.rdata(cnt_rd)
	);

	// Modify: unwritten rows read as zero, back-to-back hits take the pending word
	assign old_rule = b1_fwd_q ? b1_fwd_data_q : (row_ok_q[b1_addr_q] ? rule_rd : '0);
	assign new_rule = old_rule | b1_mask_q;
	assign rule_we  = b1_v_q && (b1_op_q == tarl_pkg::OP_TILE) && b1_en_q;
	assign old_cnt  = cnt_ok_q[b1_caddr_q] ? cnt_rd : '0;
	assign new_cnt  = (old_cnt == '1) ? old_cnt : old_cnt + COUNT_BITS'(1);
	assign cnt_we   = b1_v_q && (b1_op_q == tarl_pkg::OP_TILE) && b1_cnt_q;

	// Saturate counts to the 32-bit result fields
	assign cnt_ext = EXT'(old_cnt);
	assign tot_ext = EXT'(total_q);
	assign cnt_out = (cnt_ext > EXT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : cnt_ext[31:0];
	assign tot_out = (tot_ext > EXT'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : tot_ext[31:0];

	assign out_push = rd_in_b1;
	assign out_data = {b1_qok_q ? 64'(old_rule) : 64'd0, b1_qok_q ? cnt_out : 32'd0, tot_out};

	// Step through the four marks of a tile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (head_v && go) begin
			step_q <= last ? 2'd0 : step_q + 2'd1;
		end
	end

	// Stage two valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b1_v_q <= 1'b0;
		end else begin
			b1_v_q <= head_v && go;
		end
	end

	// Stage two payload
	always_ff @(posedge clk) begin
		b1_op_q       <= head.op;
		b1_addr_q     <= i_addr;
		b1_mask_q     <= {{(NUM_STATES - 1){1'b0}}, 1'b1} << i_nb;
		b1_en_q       <= i_en;
		b1_cnt_q      <= i_cnt;
		b1_caddr_q    <= i_caddr;
		b1_qok_q      <= i_qok;
		b1_fwd_q      <= rule_we && (b1_addr_q == i_addr);
		b1_fwd_data_q <= new_rule;
	end

	// Row valid bits, count valid bits and the total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_ok_q <= '0;
			cnt_ok_q <= '0;
			total_q  <= '0;
		end else if (b1_v_q && b1_op_q == tarl_pkg::OP_CLEAR) begin
			row_ok_q <= '0;
			cnt_ok_q <= '0;
			total_q  <= '0;
		end else begin
			if (rule_we) begin
				row_ok_q[b1_addr_q] <= 1'b1;
			end
			if (cnt_we) begin
				cnt_ok_q[b1_caddr_q] <= 1'b1;
				total_q <= (total_q == '1) ? total_q : total_q + COUNT_BITS'(1);
			end
		end
	end

	a_step_tile: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 2'd0 |-> head_v && head.op == tarl_pkg::OP_TILE)
		else $error("mark step active without a tile at the head");

	a_clear_total: assert property (@(posedge clk) disable iff (!arst_n)
		b1_v_q && b1_op_q == tarl_pkg::OP_CLEAR |=> total_q == '0)
		else $error("total not zero after clear");

	a_out_room: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> out_level < LW'(OUT_DEPTH))
		else $error("result beat pushed into a full queue");

endmodule
